[rtl/core/tks_pkg.sv]
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared widths, entry types and control structs for the selector blocks.
// ----------------------------------------------------------------------------
package tks_pkg;

  // Sizes of the kept set and of the payload fields.
  localparam int MAX_KEEP   = 64;
  localparam int INDEX_BITS = 20;
  localparam int SCORE_BITS = 32;
  localparam int RANK_BITS  = 6;
  localparam int CFG_BITS   = 7;
  localparam int CNT_BITS   = $clog2(MAX_KEEP + 1);

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_BITS  = ((SCORE_BITS + INDEX_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((SCORE_BITS + INDEX_BITS + RANK_BITS + 7) / 8) * 8;

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic [INDEX_BITS-1:0]        index_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [RANK_BITS-1:0]         rank_t;
  typedef logic [CFG_BITS-1:0]          cfg_t;

  // One kept candidate.
  typedef struct packed {
    score_t score;
    index_t index;
  } entry_t;

  // The whole kept set, entry 0 holds the best score.
  typedef entry_t [MAX_KEEP-1:0] row_t;

  // Snapshot load request from the insert row to the drain stage.
  typedef struct packed {
    logic load;
    cnt_t count;
  } snap_load_t;

endpackage

[rtl/core/tks_cell_row.sv]
// ----------------------------------------------------------------------------
// Top-k insert row
// A row of cells holding the kept set in descending score order. Every cell
// compares the offered score with its own and either holds, takes the new
// entry or takes its upper neighbor.
// ----------------------------------------------------------------------------
module tks_cell_row
  import tks_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   offer,     // candidate is offered this cycle
  input  logic   clear,     // run ends this cycle, empty the set afterwards
  input  entry_t new_entry,
  input  cnt_t   limit,     // effective keep count, 1..MAX_KEEP
  output row_t   row_upd,   // set after this cycle's offer
  output cnt_t   count_upd  // fill level after this cycle's offer
);

  row_t                row_r;
  cnt_t                count_r;
  logic [MAX_KEEP-1:0] ge;
  logic                lt_any;
  logic                full;
  logic                take;

  // Per-cell compare: a kept entry stays ahead of a new one with equal score.
  always_comb begin
    lt_any = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      ge[i] = (CNT_BITS'(i) < count_r) &&
              ($signed(row_r[i].score) >= $signed(new_entry.score));
      lt_any = lt_any | ((CNT_BITS'(i) < count_r) && !ge[i]);
    end
  end

  // A full set takes the entry only when it beats the smallest kept score.
  assign full = (count_r >= limit);
  assign take = offer && (!full || lt_any);

  // Compare-and-shift insert; the smallest entry falls off when full.
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (!take || ge[i]) begin
        row_upd[i] = row_r[i];
      end else if (i == 0) begin
        row_upd[i] = new_entry;
      end else if (ge[i-1]) begin
        row_upd[i] = new_entry;
      end else begin
        row_upd[i] = row_r[i-1];
      end
    end
    count_upd = (take && !full) ? count_r + 1'b1 : count_r;
  end

  // Cell payload needs no reset, the fill count governs what is read.
  always_ff @(posedge clk) begin
    row_r <= row_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clear) begin
      count_r <= '0;
    end else begin
      count_r <= count_upd;
    end
  end

`ifndef ASSERT_OFF
  // The fill level never runs past the size of the row.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_KEEP))
    else $error("kept count exceeds row size");

  // The end of a run leaves an empty set.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (count_r == '0))
    else $error("set not cleared after last item");

  // A candidate is only kept when one was offered.
  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (!offer && !clear) |=> $stable(count_r))
    else $error("fill level changed without an offer");
`endif

endmodule

[rtl/core/tks_drain.sv]
// ----------------------------------------------------------------------------
// Top-k result drain
// Snapshots the finished set into a shift line; sends one result beat per cycle
// while the sink is ready, via the output register, with rank and last marks.
// ----------------------------------------------------------------------------
module tks_drain
  import tks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  snap_load_t snap_load,
  input  row_t       row,
  output logic       busy,
  output logic       res_valid,
  input  logic       res_ready,
  output score_t     res_score,
  output index_t     res_index,
  output rank_t      res_rank,
  output logic       res_valid_flag,
  output logic       res_last
);

  row_t  snap_r;
  cnt_t  left_r;
  rank_t rank_r;
  logic  busy_r;
  logic  out_valid_r;
  logic  feed;
  logic  final_beat;

  // Move the next entry into the output register when it is free.
  assign feed       = busy_r && (!out_valid_r || res_ready);
  assign final_beat = (left_r == cnt_t'(0)) || (left_r == cnt_t'(1));

  // Control: snapshot occupancy and output beat valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (snap_load.load) begin
        busy_r <= 1'b1;
      end else if (feed && final_beat) begin
        busy_r <= 1'b0;
      end
      if (feed) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Snapshot shift line, entries leave from position 0.
  always_ff @(posedge clk) begin
    if (snap_load.load) begin
      snap_r <= row;
      left_r <= snap_load.count;
      rank_r <= '0;
    end else if (feed) begin
      for (int i = 0; i < MAX_KEEP - 1; i++) begin
        snap_r[i] <= snap_r[i+1];
      end
      if (left_r != cnt_t'(0)) begin
        left_r <= left_r - 1'b1;
      end
      rank_r <= rank_r + 1'b1;
    end
  end

  // Output register; an empty run yields one marker beat, all zero but for last.
  always_ff @(posedge clk) begin
    if (feed) begin
      if (left_r == cnt_t'(0)) begin
        res_score      <= '0;
        res_index      <= '0;
        res_rank       <= '0;
        res_valid_flag <= 1'b0;
        res_last       <= 1'b1;
      end else begin
        res_score      <= snap_r[0].score;
        res_index      <= snap_r[0].index;
        res_rank       <= rank_r;
        res_valid_flag <= 1'b1;
        res_last       <= (left_r == cnt_t'(1));
      end
    end
  end

  assign busy      = busy_r;
  assign res_valid = out_valid_r;

`ifndef ASSERT_OFF
  // A new snapshot never overwrites one that is still draining.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load.load |-> !busy_r)
    else $error("snapshot loaded while busy");

  // A snapshot load always marks the drain busy.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load.load |=> busy_r)
    else $error("snapshot load lost");

  // The run's last beat leaves the snapshot empty.
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (feed && final_beat) |=> !busy_r)
    else $error("drain still busy after last beat");
`endif

endmodule

[rtl/core/top_k_score_selector.sv]
// ----------------------------------------------------------------------------
// Top-k score selector
// Streaming selection of the best keep_count scored candidates per query.
// ----------------------------------------------------------------------------
// The block takes one candidate beat per clock while no tlast beat waits.
// Each beat passes an input register and is then inserted into a row of
// compare-and-shift cells. On the beat with tlast set, the finished set
// (descending score, ties earliest first) is copied into a snapshot shift
// line and the set is cleared; the snapshot then drains one result beat
// per clock while the sink is ready, ranks from 0, with tlast on the final
// result, or a single beat with tuser low when nothing was kept. With a
// free snapshot and a ready sink, a run's tlast beat passes the input
// register, the snapshot shift line and the output register before its
// first result beat is valid. Candidates of the next query keep flowing
// meanwhile; only a further tlast beat waits in the input register until
// the previous run's results, at most 64, have all left the snapshot,
// which takes longer while the sink stalls.
// ----------------------------------------------------------------------------
module top_k_score_selector
  import tks_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration: keep_count
  input  logic                      cfg_wr_en,
  input  logic [CFG_BITS-1:0]       cfg_wr_data,
  // Candidate stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // score, cand_index, zero pad
  input  logic                      in_tuser,   // skip
  input  logic                      in_tlast,   // last_cand
  // Result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // out_score, out_index, rank, zero pad
  output logic                      out_tuser,  // valid_res
  output logic                      out_tlast   // last_out
);

  cfg_t       keep_count_r;
  cnt_t       limit;
  logic       in_valid_r;
  entry_t     in_entry_r;
  logic       in_skip_r;
  logic       in_last_r;
  logic       advance;
  logic       snap_busy;
  row_t       row_upd;
  cnt_t       count_upd;
  snap_load_t snap_load;
  score_t     res_score;
  index_t     res_index;
  rank_t      res_rank;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= cfg_t'(10);
    end else if (cfg_wr_en) begin
      keep_count_r <= cfg_wr_data;
    end
  end

  // Effective limit: zero counts as one, large values saturate.
  always_comb begin
    if (keep_count_r == '0) begin
      limit = cnt_t'(1);
    end else if (keep_count_r > cfg_t'(MAX_KEEP)) begin
      limit = cnt_t'(MAX_KEEP);
    end else begin
      limit = cnt_t'(keep_count_r);
    end
  end

  // A held beat moves on unless it ends a run while the snapshot is busy.
  assign advance   = in_valid_r && (!in_last_r || !snap_busy);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_entry_r.score <= score_t'(in_tdata[SCORE_BITS-1:0]);
      in_entry_r.index <= in_tdata[SCORE_BITS+INDEX_BITS-1:SCORE_BITS];
      in_skip_r        <= in_tuser;
      in_last_r        <= in_tlast;
    end
  end

  tks_cell_row u_cell_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .offer     (advance && !in_skip_r),
    .clear     (advance && in_last_r),
    .new_entry (in_entry_r),
    .limit     (limit),
    .row_upd   (row_upd),
    .count_upd (count_upd)
  );

  // The run's final set goes straight into the snapshot.
  assign snap_load.load  = advance && in_last_r;
  assign snap_load.count = count_upd;

  tks_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .snap_load      (snap_load),
    .row            (row_upd),
    .busy           (snap_busy),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_score      (res_score),
    .res_index      (res_index),
    .res_rank       (res_rank),
    .res_valid_flag (out_tuser),
    .res_last       (out_tlast)
  );

  // Result beat packing, lowest field first.
  assign out_tdata = OUT_TDATA_BITS'({res_rank, res_index, res_score});

endmodule

[tb/tks_result_checker.sv]
// ----------------------------------------------------------------------------
// Top-k score selector result checker
// Watches the configuration port and both streams of the selector. It keeps
// its own copy of the kept set, builds the ranked result list on every tlast
// beat, and compares each result beat field by field with the oldest
// expected entry.
// ----------------------------------------------------------------------------
module tks_result_checker
  import tks_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_BITS-1:0]       cfg_wr_data,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // score, cand_index, zero pad
  input  logic                      in_tuser,   // skip
  input  logic                      in_tlast,   // last_cand
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [OUT_TDATA_BITS-1:0] out_tdata,  // out_score, out_index, rank, zero pad
  input  logic                      out_tuser,  // valid_res
  input  logic                      out_tlast,  // last_out
  output int                        pending_results,
  output int                        mismatch_count
);

  localparam cfg_t KEEP_AT_RESET = 7'd10;

  // One expected result beat.
  typedef struct {
    score_t score;
    index_t index;
    rank_t  rank;
    logic   is_valid;
    logic   is_last;
  } ranked_result_t;

  ranked_result_t ranked_q[$];
  ranked_result_t head;
  ranked_result_t next_res;

  // Predicted kept set, descending score, equal scores in arrival order.
  score_t kept_score[MAX_KEEP];
  index_t kept_index[MAX_KEEP];
  int     kept_n;
  cfg_t   keep_reg;

  score_t cand_score;
  index_t cand_index;
  score_t got_score;
  index_t got_index;
  rank_t  got_rank;
  int     limit;
  int     n;
  int     pos;
  int     i;
  logic   admit;
  int     errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      keep_reg = KEEP_AT_RESET;
      kept_n   = 0;
      ranked_q.delete();
    end else begin
      if (cfg_wr_en) begin
        keep_reg = cfg_wr_data;
      end

      // Result beat: compare against the oldest expected entry.
      if (out_tvalid && out_tready) begin
        if (ranked_q.size() == 0) begin
          $error("result beat with nothing expected: out_tdata %h", out_tdata);
          errors++;
        end else begin
          head      = ranked_q.pop_front();
          got_score = out_tdata[SCORE_BITS-1:0];
          got_index = out_tdata[SCORE_BITS +: INDEX_BITS];
          got_rank  = out_tdata[SCORE_BITS+INDEX_BITS +: RANK_BITS];
          if (got_score !== head.score) begin
            $error("out_score: expected %0d, got %0d", head.score, got_score);
            errors++;
          end
          if (got_index !== head.index) begin
            $error("out_index: expected %0d, got %0d", head.index, got_index);
            errors++;
          end
          if (got_rank !== head.rank) begin
            $error("rank: expected %0d, got %0d", head.rank, got_rank);
            errors++;
          end
          if (out_tuser !== head.is_valid) begin
            $error("valid_res: expected %0b, got %0b", head.is_valid, out_tuser);
            errors++;
          end
          if (out_tlast !== head.is_last) begin
            $error("last_out: expected %0b, got %0b", head.is_last, out_tlast);
            errors++;
          end
        end
      end

      // Candidate beat: offer it to the kept set, then emit on the last one.
      if (in_tvalid && in_tready) begin
        cand_score = in_tdata[SCORE_BITS-1:0];
        cand_index = in_tdata[SCORE_BITS +: INDEX_BITS];
        if (!in_tuser) begin
          if (keep_reg == 0) limit = 1;
          else if (keep_reg > MAX_KEEP) limit = MAX_KEEP;
          else limit = int'(keep_reg);
          n     = kept_n;
          admit = 1'b1;
          // A full set only takes a strictly better score and drops its
          // smallest entry, the latest one among equal smallest scores.
          if (n >= limit) begin
            if (cand_score > kept_score[n-1]) n--;
            else admit = 1'b0;
          end
          if (admit) begin
            pos = 0;
            while (pos < n && kept_score[pos] >= cand_score) pos++;
            for (i = n; i > pos; i--) begin
              kept_score[i] = kept_score[i-1];
              kept_index[i] = kept_index[i-1];
            end
            kept_score[pos] = cand_score;
            kept_index[pos] = cand_index;
            kept_n = n + 1;
          end
        end
        if (in_tlast) begin
          if (kept_n == 0) begin
            next_res.score    = '0;
            next_res.index    = '0;
            next_res.rank     = '0;
            next_res.is_valid = 1'b0;
            next_res.is_last  = 1'b1;
            ranked_q.insert(ranked_q.size(), next_res);
          end else begin
            for (i = 0; i < kept_n; i++) begin
              next_res.score    = kept_score[i];
              next_res.index    = kept_index[i];
              next_res.rank     = rank_t'(i);
              next_res.is_valid = 1'b1;
              next_res.is_last  = (i == kept_n - 1);
              ranked_q.insert(ranked_q.size(), next_res);
            end
          end
          kept_n = 0;
        end
      end
    end
    pending_results <= ranked_q.size();
    mismatch_count  <= errors;
  end

endmodule

[tb/tb_top_k_score_selector.sv]
// ----------------------------------------------------------------------------
// Top-k score selector testbench
// Drives directed and random candidate queries through the selector under
// several idle and stall mixes and keep counts, including a long sink
// hold-off that backs up the input. A checker beside the block predicts and
// compares every result beat; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top_k_score_selector;
  import tks_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     HOLD_CYCLES   = 300;
  localparam score_t SCORE_MAX     = 32'sh7FFF_FFFF;
  localparam score_t SCORE_MIN     = 32'sh8000_0000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_BITS-1:0]       cfg_wr_data;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // score, cand_index, zero pad
  logic                      in_tuser;   // skip
  logic                      in_tlast;   // last_cand
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // out_score, out_index, rank, zero pad
  logic                      out_tuser;  // valid_res
  logic                      out_tlast;  // last_out

  int results_pending;
  int mismatches;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_request  = 0;
  int hold_left;
  int cycle_count;
  int phase;

  top_k_score_selector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  tks_result_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .pending_results (results_pending),
    .mismatch_count  (mismatches)
  );

  // Clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Cycle limit for a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one candidate beat, with random gaps ahead of it, and wait for it
  // to be taken.
  task automatic send_candidate(input score_t score, input index_t idx,
                                input logic skip, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_BITS-SCORE_BITS-INDEX_BITS){1'b0}}, idx, score};
    in_tuser  <= skip;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result beat has left,
  // then let the block settle.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep_count(input cfg_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random queries: mostly short, now and then long; scores mix extremes,
  // a narrow band that makes ties, and full-range values.
  task automatic run_random_queries(input int n_items);
    int     sent;
    int     qlen;
    int     k;
    score_t sc;
    logic   sk;
    sent = 0;
    while (sent < n_items) begin
      qlen = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      for (k = 0; k < qlen; k++) begin
        case ($urandom_range(9))
          0:       sc = SCORE_MAX;
          1:       sc = SCORE_MIN;
          2, 3, 4: sc = score_t'($urandom_range(6)) - 3;
          default: sc = score_t'($urandom);
        endcase
        sk = ($urandom_range(99) < 15);
        send_candidate(sc, index_t'($urandom), sk, k == qlen - 1);
      end
      sent += qlen;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    in_tlast    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset keep count of 10. A lone skipped last beat gives
    // the empty marker; a lone kept one gives a single result.
    send_candidate(32'sd5, 20'd1, 1'b1, 1'b1);
    send_candidate(SCORE_MAX, 20'hFFFFF, 1'b0, 1'b1);

    // Fill the set with extremes and ties, then offer a score equal to the
    // minimum (refused), a skipped one, and a better one that evicts.
    send_candidate(SCORE_MIN, 20'd0, 1'b0, 1'b0);
    send_candidate(SCORE_MAX, 20'hFFFFF, 1'b0, 1'b0);
    send_candidate(-32'sd1, 20'd2, 1'b0, 1'b0);
    send_candidate(32'sd0, 20'd3, 1'b0, 1'b0);
    send_candidate(32'sd1, 20'd4, 1'b0, 1'b0);
    send_candidate(32'sd100, 20'd5, 1'b0, 1'b0);
    send_candidate(32'sd100, 20'd6, 1'b0, 1'b0);
    send_candidate(-32'sd5, 20'd7, 1'b0, 1'b0);
    send_candidate(32'sd3, 20'd8, 1'b0, 1'b0);
    send_candidate(32'sd2, 20'd9, 1'b0, 1'b0);
    send_candidate(SCORE_MIN, 20'd10, 1'b0, 1'b0);
    send_candidate(32'sd100, 20'd11, 1'b1, 1'b0);
    send_candidate(-32'sd1, 20'd12, 1'b0, 1'b1);
    wait_results_drained();

    // A keep count of zero acts as one: the earliest of equal scores stays.
    write_keep_count(7'd0);
    send_candidate(32'sd4, 20'd20, 1'b0, 1'b0);
    send_candidate(32'sd4, 20'd21, 1'b0, 1'b0);
    send_candidate(32'sd4, 20'd22, 1'b0, 1'b1);
    wait_results_drained();

    // Keep count lowered in the middle of a query: the set stays at four.
    write_keep_count(7'd4);
    send_candidate(32'sd9, 20'd30, 1'b0, 1'b0);
    send_candidate(32'sd8, 20'd31, 1'b0, 1'b0);
    send_candidate(32'sd7, 20'd32, 1'b0, 1'b0);
    send_candidate(32'sd6, 20'd33, 1'b0, 1'b0);
    wait_results_drained();
    write_keep_count(7'd2);
    send_candidate(32'sd10, 20'd34, 1'b0, 1'b0);
    send_candidate(32'sd5, 20'd35, 1'b0, 1'b1);
    wait_results_drained();

    // Back-pressure: the sink holds off while short queries keep coming, so
    // the snapshot stays full and the input stalls. Keep count saturates.
    write_keep_count(7'd127);
    hold_request = HOLD_CYCLES;
    repeat (10) begin
      send_candidate(score_t'($urandom), index_t'($urandom), 1'b0, 1'b0);
      send_candidate(score_t'($urandom), index_t'($urandom), 1'b0, 1'b0);
      send_candidate(score_t'($urandom), index_t'($urandom), 1'b1, 1'b0);
      send_candidate(score_t'($urandom), index_t'($urandom), 1'b0, 1'b1);
    end
    wait_results_drained();

    // Random phases with different idle mixes and keep counts.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
          write_keep_count(7'd64);
        end
        1: begin
          snd_idle_pct  = 49;
          rcv_stall_pct = 0;
          write_keep_count(cfg_t'($urandom_range(2, 9)));
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 49;
          write_keep_count(7'd1);
        end
        default: begin
          snd_idle_pct  = 20;
          rcv_stall_pct = 20;
          write_keep_count(cfg_t'($urandom_range(10, 63)));
        end
      endcase
      run_random_queries(90);
      wait_results_drained();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tks_pkg.sv
rtl/core/tks_cell_row.sv
rtl/core/tks_drain.sv
rtl/core/top_k_score_selector.sv
tb/tks_result_checker.sv
tb/tb_top_k_score_selector.sv
